// ===== rtl/sgdlf_pkg.sv =====
`timescale 1ns / 1ps
// sgdlf_pkg: shared types, constants and helpers of the sgd latent factor update unit
// no dependencies
package sgdlf_pkg;

	localparam int LATENT_SIZE = 2;
	localparam int FRAC_BITS = 24;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 31;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REG_WEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REQUEUE_THRESHOLD = 2'd2;

	localparam logic [23:0] LEARN_RATE_RST = 24'd13245;
	localparam logic [23:0] REG_WEIGHT_RST = 24'd16777;
	localparam logic [30:0] REQUEUE_THRESHOLD_RST = 31'd335544320;

	typedef struct packed {
		logic [23:0] learn_rate;
		logic [23:0] reg_weight;
		logic [30:0] requeue_threshold;
	} cfg_t;

	// latent vectors as raw two's complement words
	typedef struct packed {
		logic [31:0] u0;
		logic [31:0] u1;
		logic [31:0] m0;
		logic [31:0] m1;
	} vec_t;

	// error stage to update stage
	typedef struct packed {
		logic        valid;
		vec_t        x;
		logic [7:0]  rating;
		logic [41:0] err;
		logic [31:0] err_sat;
	} err_t;

	// update stage to check stage
	typedef struct packed {
		logic        valid;
		vec_t        nx;
		logic [7:0]  rating;
		logic [41:0] err;
	} upd_t;

	// check stage to output
	typedef struct packed {
		logic        valid;
		vec_t        nx;
		logic        requeue;
	} res_t;

	// saturate a 44-bit two's complement value to 32 bits
	function automatic logic [31:0] sat32(input logic [43:0] v);
		logic [31:0] r;
		r = v[31:0];
		if (!v[43] && (|v[42:31])) begin
			r = 32'h7fff_ffff;
		end else if (v[43] && !(&v[42:31])) begin
			r = 32'h8000_0000;
		end
		return r;
	endfunction

endpackage

// ===== rtl/sgdlf_item_if.sv =====
`timescale 1ns / 1ps
// sgdlf_item_if: request channel carrying one rating edge
// no dependencies
interface sgdlf_item_if;
	logic        valid;
	logic        ready;
	logic [31:0] user_x0;
	logic [31:0] user_x1;
	logic [31:0] movie_x0;
	logic [31:0] movie_x1;
	logic [7:0]  rating;

	modport source (output valid, user_x0, user_x1, movie_x0, movie_x1, rating, input ready);
	modport sink (input valid, user_x0, user_x1, movie_x0, movie_x1, rating, output ready);
endinterface

// ===== rtl/sgdlf_result_if.sv =====
`timescale 1ns / 1ps
// sgdlf_result_if: result channel carrying updated vectors and the requeue flag
// no dependencies
interface sgdlf_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] new_user_x0;
	logic [31:0] new_user_x1;
	logic [31:0] new_movie_x0;
	logic [31:0] new_movie_x1;
	logic        requeue;

	modport source (output valid, new_user_x0, new_user_x1, new_movie_x0, new_movie_x1,
		requeue, input ready);
	modport sink (input valid, new_user_x0, new_user_x1, new_movie_x0, new_movie_x1,
		requeue, output ready);
endinterface

// ===== rtl/sgdlf_cfg.sv =====
`timescale 1ns / 1ps
// sgdlf_cfg: configuration registers written through a plain write port
// depends on sgdlf_pkg
module sgdlf_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [sgdlf_pkg::CFG_IDX_W-1:0]  index,
	input  logic [sgdlf_pkg::CFG_DATA_W-1:0] wdata,
	output sgdlf_pkg::cfg_t                 cfg
);
	import sgdlf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.learn_rate <= LEARN_RATE_RST;
			cfg_q.reg_weight <= REG_WEIGHT_RST;
			cfg_q.requeue_threshold <= REQUEUE_THRESHOLD_RST;
		end else if (we) begin
			case (index)
				CFG_LEARN_RATE: cfg_q.learn_rate <= wdata[23:0];
				CFG_REG_WEIGHT: cfg_q.reg_weight <= wdata[23:0];
				CFG_REQUEUE_THRESHOLD: cfg_q.requeue_threshold <= wdata[30:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== rtl/sgdlf_err.sv =====
`timescale 1ns / 1ps
// sgdlf_err: dot product of the old vectors and prediction error, two stages
// depends on sgdlf_pkg
module sgdlf_err (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  sgdlf_pkg::vec_t   in_x,
	input  logic [7:0]        in_rating,
	output sgdlf_pkg::err_t   o
);
	import sgdlf_pkg::*;

	logic        v_s1, v_s2;
	vec_t        x_s1, x_s2;
	logic [7:0]  rating_s1, rating_s2;
	logic [63:0] p0_s1, p1_s1;
	logic [41:0] err_s2;
	logic [31:0] err_sat_s2;

	logic signed [63:0] p0, p1;
	logic [40:0] dp;
	logic [41:0] err;
	logic [31:0] r;

	always_comb begin
		p0 = $signed(in_x.u0) * $signed(in_x.m0);
		p1 = $signed(in_x.u1) * $signed(in_x.m1);
	end

	// floor shift of each product, then rating minus prediction
	always_comb begin
		dp = {p0_s1[63], p0_s1[63:24]};
		if (LATENT_SIZE > 1) begin
			dp = dp + {p1_s1[63], p1_s1[63:24]};
		end
		r = {rating_s1, 24'd0};
		err = {{10{r[31]}}, r} - {dp[40], dp};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= in_x;
			rating_s1 <= in_rating;
			p0_s1 <= p0;
			p1_s1 <= p1;
			x_s2 <= x_s1;
			rating_s2 <= rating_s1;
			err_s2 <= err;
			err_sat_s2 <= sat32({{2{err[41]}}, err});
		end
	end

	assign o.valid = v_s2;
	assign o.x = x_s2;
	assign o.rating = rating_s2;
	assign o.err = err_s2;
	assign o.err_sat = err_sat_s2;
endmodule

// ===== rtl/sgdlf_upd.sv =====
`timescale 1ns / 1ps
// sgdlf_upd: gradient step on all four elements, four stages
// depends on sgdlf_pkg
module sgdlf_upd (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  sgdlf_pkg::cfg_t cfg,
	input  sgdlf_pkg::err_t i,
	output sgdlf_pkg::upd_t o
);
	import sgdlf_pkg::*;

	// element order: u0, u1, m0, m1; the partner of a user element is the movie element
	logic        v_s3, v_s4, v_s5, v_s6;
	vec_t        x_s3, x_s4, x_s5;
	logic [7:0]  rating_s3, rating_s4, rating_s5, rating_s6;
	logic [41:0] err_s3, err_s4, err_s5, err_s6;
	logic [63:0] ep_s3 [4];
	logic [56:0] rp_s3 [4];
	logic [40:0] grad_s4 [4];
	logic [47:0] pl_s5 [4];
	logic [41:0] ph_s5 [4];
	logic [31:0] nx_s6 [4];

	logic [31:0] self_i [4];
	logic [31:0] other_i [4];
	logic [31:0] self_s5 [4];
	logic signed [63:0] ep [4];
	logic signed [56:0] rp [4];
	logic [40:0] grad [4];
	logic [47:0] pl [4];
	logic signed [41:0] ph [4];
	logic [43:0] delta [4];
	logic [43:0] sum [4];
	logic [31:0] nx [4];

	always_comb begin
		self_i[0] = i.x.u0;
		self_i[1] = i.x.u1;
		self_i[2] = i.x.m0;
		self_i[3] = i.x.m1;
		other_i[0] = i.x.m0;
		other_i[1] = i.x.m1;
		other_i[2] = i.x.u0;
		other_i[3] = i.x.u1;
		self_s5[0] = x_s5.u0;
		self_s5[1] = x_s5.u1;
		self_s5[2] = x_s5.m0;
		self_s5[3] = x_s5.m1;
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ep[k] = $signed(i.err_sat) * $signed(other_i[k]);
			rp[k] = $signed({1'b0, cfg.reg_weight}) * $signed(self_i[k]);
			grad[k] = {ep_s3[k][63], ep_s3[k][63:24]}
				- {{8{rp_s3[k][56]}}, rp_s3[k][56:24]};
			// split the wide gradient so each multiplier stays narrow
			pl[k] = cfg.learn_rate * grad_s4[k][23:0];
			ph[k] = $signed({1'b0, cfg.learn_rate}) * $signed(grad_s4[k][40:24]);
			delta[k] = {{2{ph_s5[k][41]}}, ph_s5[k]} + {20'd0, pl_s5[k][47:24]};
			sum[k] = {{12{self_s5[k][31]}}, self_s5[k]} + delta[k];
			nx[k] = sat32(sum[k]);
			// element 1 passes unchanged when only one latent element is used
			if (LATENT_SIZE < 2 && (k == 1 || k == 3)) begin
				nx[k] = self_s5[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s3 <= i.valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3 <= i.x;
			x_s4 <= x_s3;
			x_s5 <= x_s4;
			rating_s3 <= i.rating;
			rating_s4 <= rating_s3;
			rating_s5 <= rating_s4;
			rating_s6 <= rating_s5;
			err_s3 <= i.err;
			err_s4 <= err_s3;
			err_s5 <= err_s4;
			err_s6 <= err_s5;
			for (int k = 0; k < 4; k++) begin
				ep_s3[k] <= ep[k];
				rp_s3[k] <= rp[k];
				grad_s4[k] <= grad[k];
				pl_s5[k] <= pl[k];
				ph_s5[k] <= ph[k];
				nx_s6[k] <= nx[k];
			end
		end
	end

	assign o.valid = v_s6;
	assign o.nx.u0 = nx_s6[0];
	assign o.nx.u1 = nx_s6[1];
	assign o.nx.m0 = nx_s6[2];
	assign o.nx.m1 = nx_s6[3];
	assign o.rating = rating_s6;
	assign o.err = err_s6;
endmodule

// ===== rtl/sgdlf_chk.sv =====
`timescale 1ns / 1ps
// sgdlf_chk: prediction from the new vectors and the requeue test, four stages
// depends on sgdlf_pkg
module sgdlf_chk (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  sgdlf_pkg::cfg_t cfg,
	input  sgdlf_pkg::upd_t i,
	output sgdlf_pkg::res_t o
);
	import sgdlf_pkg::*;

	logic        v_s7, v_s8, v_s9, v_s10;
	vec_t        nx_s7, nx_s8, nx_s9, nx_s10;
	logic [63:0] q0_s7, q1_s7;
	logic [43:0] emr_s7, emr_s8;
	logic [40:0] dp_s8;
	logic [43:0] diff_s9;
	logic        requeue_s10;

	logic signed [63:0] q0, q1;
	logic [31:0] r;
	logic [43:0] emr;
	logic [40:0] dp;
	logic signed [43:0] diff;
	logic signed [43:0] th;
	logic requeue;

	always_comb begin
		q0 = $signed(i.nx.u0) * $signed(i.nx.m0);
		q1 = $signed(i.nx.u1) * $signed(i.nx.m1);
		r = {i.rating, 24'd0};
		// e - e2 = (e - r) + dp2
		emr = {{2{i.err[41]}}, i.err} - {{12{r[31]}}, r};
		dp = {q0_s7[63], q0_s7[63:24]};
		if (LATENT_SIZE > 1) begin
			dp = dp + {q1_s7[63], q1_s7[63:24]};
		end
		diff = $signed(emr_s8 + {{3{dp_s8[40]}}, dp_s8});
		th = $signed({13'd0, cfg.requeue_threshold});
		diff = $signed(diff_s9);
		requeue = (diff > th) || (diff < -th);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s7 <= i.valid;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s7 <= i.nx;
			nx_s8 <= nx_s7;
			nx_s9 <= nx_s8;
			nx_s10 <= nx_s9;
			q0_s7 <= q0;
			q1_s7 <= q1;
			emr_s7 <= emr;
			emr_s8 <= emr_s7;
			dp_s8 <= dp;
			diff_s9 <= emr_s8 + {{3{dp_s8[40]}}, dp_s8};
			requeue_s10 <= requeue;
		end
	end

	assign o.valid = v_s10;
	assign o.nx = nx_s10;
	assign o.requeue = requeue_s10;
endmodule

// ===== rtl/sgd_latent_factor_update_unit.sv =====
`timescale 1ns / 1ps
// sgd_latent_factor_update_unit: top level of the sgd latent factor update
// one request per cycle while the pipeline is not held
// the ten-stage pipeline moves as one unit and holds only while the result is not taken
// arst_n clears all valid bits and loads the register reset values
// depends on sgdlf_pkg, sgdlf_item_if, sgdlf_result_if, sgdlf_cfg, sgdlf_err, sgdlf_upd, sgdlf_chk
module sgd_latent_factor_update_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sgdlf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sgdlf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	sgdlf_item_if.sink                       item,
	sgdlf_result_if.source                   result
);
	import sgdlf_pkg::*;

	cfg_t cfg;
	vec_t in_x;
	err_t err_o;
	upd_t upd_o;
	res_t res_o;
	logic en;

	// whole pipeline advances unless the output register holds an untaken result
	assign en = !res_o.valid || result.ready;
	assign item.ready = en;

	assign in_x.u0 = item.user_x0;
	assign in_x.u1 = item.user_x1;
	assign in_x.m0 = item.movie_x0;
	assign in_x.m1 = item.movie_x1;

	sgdlf_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	sgdlf_err u_err (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (item.valid),
		.in_x      (in_x),
		.in_rating (item.rating),
		.o         (err_o)
	);

	sgdlf_upd u_upd (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cfg    (cfg),
		.i      (err_o),
		.o      (upd_o)
	);

	sgdlf_chk u_chk (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cfg    (cfg),
		.i      (upd_o),
		.o      (res_o)
	);

	assign result.valid = res_o.valid;
	assign result.new_user_x0 = res_o.nx.u0;
	assign result.new_user_x1 = res_o.nx.u1;
	assign result.new_movie_x0 = res_o.nx.m0;
	assign result.new_movie_x1 = res_o.nx.m1;
	assign result.requeue = res_o.requeue;
endmodule
